/* src/ctlp_pkg.sv */
// Shared types and constants for the controller entry line parser.
// Holds character codes, phase and status codes and the result beat type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctlp_pkg;

    localparam int DEF_MAX_SLOTS = 32;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_MASK  = 1'd1;

    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_W     = 6;
    localparam int MASK_W      = 32;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BAR   = 8'h7c;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Largest magnitude an axis field may carry (2^31)
    localparam logic [34:0] LIMIT_MAG = 35'h0_8000_0000;

    // Parser phases
    localparam logic [2:0] PH_BETWEEN = 3'd0;
    localparam logic [2:0] PH_SPACES  = 3'd1;
    localparam logic [2:0] PH_SIGN    = 3'd2;
    localparam logic [2:0] PH_DIGITS  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_FAILED  = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_SLOT = 2'd0;
    localparam logic [1:0] STATUS_LAST = 2'd1;
    localparam logic [1:0] STATUS_FAIL = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         slot;
        logic               slot_is_axis;
        logic               pressed;
        logic signed [31:0] axis_value;
    } result_t;

endpackage

`default_nettype wire

/* src/ctlp_parse.sv */
// Per-character parser: line state registers and the single-pass next-state logic.
// Depends on ctlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctlp_parse #(
    parameter int MAX_SLOTS = ctlp_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [7:0]                    char_code,
    input  wire logic [ctlp_pkg::COUNT_W-1:0]  slot_count,
    input  wire logic [ctlp_pkg::MASK_W-1:0]   axis_slot_mask,
    output logic                               res_valid,
    output ctlp_pkg::result_t                  res
);
    import ctlp_pkg::*;

    localparam int POS_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    logic [POS_W-1:0] slot_pos_reg, slot_pos_next;
    logic [2:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [31:0]      mag_reg, mag_next;

    logic [CMP_W-1:0] eff_count;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] fin_pos_ext;
    logic [POS_W-1:0] fin_pos;
    logic             fin_last;
    logic             cur_axis;
    logic             is_digit;
    logic [3:0]       digit_val;
    logic [34:0]      mag_ext;
    logic [34:0]      mag_x10;
    logic             go_fail;
    logic             go_finish;
    logic             fin_pressed;
    logic [31:0]      fin_value;

    // Effective slot count: zero acts as one, clamp at the slot limit
    always_comb
    begin
        if (slot_count == '0)
            eff_count = CMP_W'(1);
        else if (CMP_W'(slot_count) > CMP_W'(MAX_SLOTS))
            eff_count = CMP_W'(MAX_SLOTS);
        else
            eff_count = CMP_W'(slot_count);
    end

    assign pos_ext     = CMP_W'(slot_pos_reg);
    assign fin_pos     = slot_pos_reg + POS_W'(1);
    assign fin_pos_ext = CMP_W'(fin_pos);
    assign fin_last    = (fin_pos_ext >= eff_count);
    assign cur_axis    = (pos_ext < CMP_W'(32)) ? axis_slot_mask[pos_ext[4:0]] : 1'b0;

    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit_val = 4'(char_code - CHAR_ZERO);
    assign mag_ext   = 35'(mag_reg);
    assign mag_x10   = (mag_ext << 3) + (mag_ext << 1) + 35'(digit_val);

    always_comb
    begin
        slot_pos_next = slot_pos_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        go_fail       = 1'b0;
        go_finish     = 1'b0;
        fin_pressed   = 1'b0;
        fin_value     = '0;

        if (char_code == CHAR_NUL)
        begin
            // End of line: fail a line still in progress, then rearm
            go_fail       = (phase_reg != PH_DONE) && (phase_reg != PH_FAILED);
            slot_pos_next = '0;
            phase_next    = PH_BETWEEN;
            neg_next      = 1'b0;
            mag_next      = '0;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_BETWEEN, PH_SPACES:
                begin
                    if (phase_reg == PH_BETWEEN && char_code == CHAR_BAR)
                    begin
                        phase_next = PH_BETWEEN;
                    end
                    else if (phase_reg == PH_BETWEEN && !cur_axis)
                    begin
                        go_finish   = 1'b1;
                        fin_pressed = (char_code != CHAR_DOT);
                    end
                    else if (char_code == CHAR_SPACE)
                    begin
                        phase_next = PH_SPACES;
                    end
                    else if (char_code == CHAR_PLUS || char_code == CHAR_MINUS)
                    begin
                        neg_next   = (char_code == CHAR_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        phase_next = PH_DIGITS;
                        mag_next   = 32'(digit_val);
                    end
                    else
                    begin
                        go_fail = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        phase_next = PH_DIGITS;
                        mag_next   = 32'(digit_val);
                    end
                    else
                    begin
                        go_fail = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (char_code == CHAR_COMMA)
                    begin
                        go_finish = 1'b1;
                        fin_value = neg_reg ? (32'd0 - mag_reg) : mag_reg;
                    end
                    else if (is_digit && (mag_x10 <= LIMIT_MAG))
                    begin
                        mag_next = mag_x10[31:0];
                    end
                    else
                    begin
                        go_fail = 1'b1;
                    end
                end
                default:
                begin
                    // Line done or failed: drop bytes until end of line
                    phase_next = phase_reg;
                end
            endcase

            if (go_finish)
            begin
                slot_pos_next = fin_pos;
                neg_next      = 1'b0;
                mag_next      = '0;
                phase_next    = fin_last ? PH_DONE : PH_BETWEEN;
            end
            else if (go_fail)
            begin
                phase_next = PH_FAILED;
            end
        end
    end

    always_comb
    begin
        res_valid        = accept && (go_fail || go_finish);
        res.slot         = pos_ext[4:0];
        res.slot_is_axis = cur_axis;
        if (go_fail)
        begin
            res.status     = STATUS_FAIL;
            res.pressed    = 1'b0;
            res.axis_value = '0;
        end
        else
        begin
            res.status     = fin_last ? STATUS_LAST : STATUS_SLOT;
            res.pressed    = fin_pressed;
            res.axis_value = fin_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_pos_reg <= '0;
            phase_reg    <= PH_BETWEEN;
            neg_reg      <= 1'b0;
            mag_reg      <= '0;
        end
        else if (accept)
        begin
            slot_pos_reg <= slot_pos_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            mag_reg      <= mag_next;
        end
    end

endmodule

`default_nettype wire

/* src/ctlp_skid.sv */
// Result register with one skid entry, parting the parser from the output stall.
// Depends on ctlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctlp_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  ctlp_pkg::result_t       push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ctlp_pkg::result_t       out_data
);
    import ctlp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                if (push)
                    out_data_next = push_data;
            end
        end
        else if (push)
        begin
            // Output held by a stall: park the new beat
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* src/controller_entry_line_parser_top.sv */
// Controller entry line parser, top level: configuration registers, parser, result buffer.
// Depends on ctlp_pkg, ctlp_parse and ctlp_skid.
//
// Usage:
//   Input channel (in_valid / in_stall / char_code) carries one byte of a
//   controller log line per beat; byte 0 ends the line and rearms the parser.
//   Output channel (out_valid / out_stall / status, slot, slot_is_axis,
//   pressed, axis_value) carries one beat per finished slot, or one failure
//   beat per bad line. Many bytes give no beat at all.
//   Configuration: cfg_we with cfg_index selects slot_count (index 0) or
//   axis_slot_mask (index 1); write only while no beats are outstanding.
//   Throughput: one byte per cycle while in_stall is low. The per-byte work (classify,
//   multiply the magnitude by ten, compare to the limit) is short combinational
//   logic between the parser state registers and the result register.
//   Result path: a result beat is registered in the result register, or parked in
//   the skid entry while the output is stalled, before it shows on the output.
//   Stall: the result register plus one skid entry absorb a stalled output;
//   in_stall rises only when the skid entry is occupied.
//   Reset: slot_count returns to 1, the mask to all buttons, the parser to
//   slot 0 between slots, and both result entries are emptied.
`timescale 1ns / 1ps
`default_nettype none

module controller_entry_line_parser_top #(
    parameter int MAX_SLOTS = ctlp_pkg::DEF_MAX_SLOTS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [ctlp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ctlp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // byte input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        char_code,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             status,
    output logic [4:0]                             slot,
    output logic                                   slot_is_axis,
    output logic                                   pressed,
    output logic signed [31:0]                     axis_value
);
    import ctlp_pkg::*;

    logic [COUNT_W-1:0] slot_count_reg;
    logic [MASK_W-1:0]  axis_mask_reg;
    logic               accept;
    logic               res_valid;
    result_t            res;
    result_t            out_data;
    logic               skid_full;

    // Configuration registers; no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= COUNT_W'(1);
            axis_mask_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLOT_COUNT: slot_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_AXIS_MASK:  axis_mask_reg  <= cfg_wdata[MASK_W-1:0];
                default:        slot_count_reg <= slot_count_reg;
            endcase
        end
    end

    // Take a byte whenever the skid entry is free
    assign in_stall = skid_full;
    assign accept   = in_valid && !skid_full;

    ctlp_parse #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .char_code      (char_code),
        .slot_count     (slot_count_reg),
        .axis_slot_mask (axis_mask_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    ctlp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status       = out_data.status;
    assign slot         = out_data.slot;
    assign slot_is_axis = out_data.slot_is_axis;
    assign pressed      = out_data.pressed;
    assign axis_value   = out_data.axis_value;

endmodule

`default_nettype wire
